// File: sv/oqvr_pkg.sv
// ============================================================================
// oqvr_pkg
// Types and codes shared by the ordered queue with value removal.
// ============================================================================
package oqvr_pkg;

    localparam int OP_W     = 2;
    localparam int RES_W    = 32;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] VSEL_ZERO  = 2'd0;
    localparam logic [1:0] VSEL_RDATA = 2'd1;
    localparam logic [1:0] VSEL_FOUND = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [RES_W-1:0] operand_value;
    } t_in;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
    } t_out;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              push_wr;
        logic              pop_done;
        logic              found;
        logic              shift_wr;
        logic              take_done;
        logic              resp;
        logic [STAT_W-1:0] resp_status;
        logic [1:0]        resp_vsel;
    } t_ctl_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic pend;
        logic match;
    } t_ctl_sts;

endpackage

// File: sv/ordered_queue_with_value_removal.sv
// ============================================================================
// ordered_queue_with_value_removal
// Bounded ordered queue of signed words with push, pop and remove by value.
// ============================================================================
// A transaction is taken when start is high and busy is low; its one result
// appears on o_result for a single cycle with o_strobe high, and the receiver
// cannot stall it. Push, the unused operation code, and pop or remove on an
// empty queue answer straight from the idle state; pop on a non-empty queue
// answers from the pop state. Remove walks the queue through the store's
// single registered read port one entry per cycle, then closes the gap by
// copying each later entry forward one per cycle. A new transaction may
// start in the cycle its predecessor's result is shown.
module ordered_queue_with_value_removal #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  oqvr_pkg::t_in  i_cmd,
    output logic           busy,
    output oqvr_pkg::t_out o_result,
    output logic           o_strobe
);
    import oqvr_pkg::*;

    t_ctl_cmd ctl;
    t_ctl_sts sts;

    oqvr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    oqvr_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule

// File: sv/oqvr_ram.sv
// ============================================================================
// oqvr_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module oqvr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/oqvr_ctrl.sv
// ============================================================================
// oqvr_ctrl
// Sequencer for push, pop and remove transactions.
// ============================================================================
module oqvr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  oqvr_pkg::t_in      i_cmd,
    input  oqvr_pkg::t_ctl_sts i_sts,
    output oqvr_pkg::t_ctl_cmd o_ctl,
    output logic               busy
);
    import oqvr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_SHIFT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_ctl_cmd   ctl;

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_cmd.operation)
                        OP_PUSH: begin
                            ctl.resp = 1'b1;
                            if (i_sts.full) begin
                                ctl.resp_status = ST_FULL;
                            end else begin
                                ctl.push_wr = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (i_sts.empty) begin
                                ctl.resp        = 1'b1;
                                ctl.resp_status = ST_EMPTY;
                            end else begin
                                ctl.load = 1'b1;
                                ctl.step = 1'b1;
                                n_state  = S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_sts.empty) begin
                                ctl.resp        = 1'b1;
                                ctl.resp_status = ST_EMPTY;
                            end else begin
                                ctl.load = 1'b1;
                                ctl.step = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            ctl.resp = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                ctl.pop_done  = 1'b1;
                ctl.resp      = 1'b1;
                ctl.resp_vsel = VSEL_RDATA;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                if (!i_sts.pend) begin
                    ctl.resp        = 1'b1;
                    ctl.resp_status = ST_NOT_FOUND;
                    n_state         = S_IDLE;
                end else if (i_sts.match) begin
                    ctl.found = 1'b1;
                    ctl.step  = 1'b1;
                    n_state   = S_SHIFT;
                end else begin
                    ctl.step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_sts.pend) begin
                    ctl.shift_wr = 1'b1;
                    ctl.step     = 1'b1;
                end else begin
                    ctl.take_done = 1'b1;
                    ctl.resp      = 1'b1;
                    ctl.resp_vsel = VSEL_FOUND;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl = ctl;
    assign busy  = (r_state != S_IDLE);

endmodule

// File: sv/oqvr_dpath.sv
// ============================================================================
// oqvr_dpath
// Circular value store with head pointer, scan/shift pointers and result
// register.
// ============================================================================
module oqvr_dpath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oqvr_pkg::t_in      i_cmd,
    input  oqvr_pkg::t_ctl_cmd i_ctl,
    output oqvr_pkg::t_ctl_sts o_sts,
    output oqvr_pkg::t_out     o_result,
    output logic               o_strobe
);
    import oqvr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [AW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_ridx, n_ridx;
    logic [CW-1:0]          r_pidx, n_pidx;
    logic [VALUE_WIDTH-1:0] r_key, n_key;
    logic [VALUE_WIDTH-1:0] r_fval, n_fval;
    t_out                   r_result, n_result;
    logic                   r_strobe;

    logic [CW-1:0]          rd_idx;
    logic [AW-1:0]          raddr;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] rdata;
    logic                   we;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(idx);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_idx = i_ctl.load ? '0 : r_ridx;
    assign raddr  = phys(r_head, rd_idx);
    assign we     = i_ctl.push_wr | i_ctl.shift_wr;
    assign waddr  = i_ctl.push_wr ? phys(r_head, r_count)
                                  : phys(r_head, r_pidx - CW'(1));
    assign wdata  = i_ctl.push_wr ? VALUE_WIDTH'($unsigned(i_cmd.operand_value)) : rdata;

    oqvr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_ridx   = r_ridx;
        n_pidx   = r_pidx;
        n_key    = r_key;
        n_fval   = r_fval;
        n_result = r_result;

        if (i_ctl.load) begin
            n_key = VALUE_WIDTH'($unsigned(i_cmd.operand_value));
        end
        if (i_ctl.step) begin
            n_pidx = rd_idx;
            n_ridx = (rd_idx == r_count) ? rd_idx : rd_idx + CW'(1);
        end
        if (i_ctl.found) begin
            n_fval = rdata;
        end
        if (i_ctl.pop_done) begin
            n_head = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
        end
        if (i_ctl.push_wr) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop_done || i_ctl.take_done) begin
            n_count = r_count - CW'(1);
        end

        if (i_ctl.resp) begin
            n_result.status    = i_ctl.resp_status;
            n_result.occupancy = OCC_W'(n_count);
            unique case (i_ctl.resp_vsel)
                VSEL_RDATA: n_result.result_value = RES_W'(signed'(rdata));
                VSEL_FOUND: n_result.result_value = RES_W'(signed'(r_fval));
                default:    n_result.result_value = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= i_ctl.resp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_pidx   <= n_pidx;
        r_key    <= n_key;
        r_fval   <= n_fval;
        r_result <= n_result;
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_sts.pend  = (r_pidx < r_count);
    assign o_sts.match = (rdata == r_key);
    assign o_result    = r_result;
    assign o_strobe    = r_strobe;

endmodule

// File: sv/oqvr_chk.sv
// ============================================================================
// oqvr_chk
// Port-level checks on transaction flow and result encoding.
// ============================================================================
module oqvr_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input oqvr_pkg::t_in  i_cmd,
    input logic           busy,
    input oqvr_pkg::t_out o_result,
    input logic           o_strobe
);
    import oqvr_pkg::*;

    a_strobe_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a transaction in progress");

    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transaction neither busy nor answered");

    a_done_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |-> (o_result.result_value == '0))
        else $error("nonzero value with error status");

endmodule

bind ordered_queue_with_value_removal oqvr_chk u_chk (.*);

// File: test/oqvr_result_check.sv
// ============================================================================
// oqvr_result_check
// Result checker for the ordered queue with value removal.
// ----------------------------------------------------------------------------
// Watches the command and result channels. Each accepted transaction is run
// through a behavioral copy of the queue, and the answer it gives is queued.
// Each strobed result is compared field by field with the oldest queued
// answer. Reports the mismatch count and the number of answers still waiting.
// ============================================================================
module oqvr_result_check
    import oqvr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_in  i_cmd,
    input  t_out i_result,
    input  logic i_strobe,
    output int   o_mismatches,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic signed [RES_W-1:0] queued_values [QUEUE_DEPTH];
    int                      queued_count = 0;
    t_out                    expected_answers [$];
    int                      mismatch_count = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic apply_queue_op(input t_in cmd, output t_out answer);
        int hit;
        hit                 = -1;
        answer.result_value = '0;
        answer.status       = ST_OK;
        case (cmd.operation)
            OP_PUSH: begin
                if (queued_count >= QUEUE_DEPTH) begin
                    answer.status = ST_FULL;
                end else begin
                    queued_values[queued_count] = cmd.operand_value;
                    queued_count++;
                end
            end
            OP_POP: begin
                if (queued_count == 0) begin
                    answer.status = ST_EMPTY;
                end else begin
                    hit = 0;
                end
            end
            OP_REMOVE: begin
                if (queued_count == 0) begin
                    answer.status = ST_EMPTY;
                end else begin
                    for (int i = queued_count - 1; i >= 0; i--) begin
                        if (queued_values[i] == cmd.operand_value) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        answer.status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            answer.result_value = queued_values[hit];
            for (int i = hit; i + 1 < queued_count; i++) begin
                queued_values[i] = queued_values[i + 1];
            end
            queued_count--;
        end
        answer.occupancy = queued_count[OCC_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_out answer;
        t_out oldest;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                apply_queue_op(i_cmd, answer);
                expected_answers.push_back(answer);
            end
            if (i_strobe) begin
                if (expected_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result with no transaction pending: value %0d status %0d occupancy %0d",
                                 $realtime, i_result.result_value, i_result.status,
                                 i_result.occupancy);
                    end
                end else begin
                    oldest = expected_answers.pop_front();
                    if (oldest.result_value !== i_result.result_value ||
                        oldest.status       !== i_result.status ||
                        oldest.occupancy    !== i_result.occupancy) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: expected value %0d status %0d occupancy %0d",
                                     $realtime, oldest.result_value, oldest.status,
                                     oldest.occupancy);
                            $display("%0t:      got value %0d status %0d occupancy %0d",
                                     $realtime, i_result.result_value, i_result.status,
                                     i_result.occupancy);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_answers.size();
    end

endmodule

// File: test/testbench.sv
// ============================================================================
// testbench
// Stimulus and verdict for the ordered queue with value removal.
// ----------------------------------------------------------------------------
// Runs a directed sequence over empty, full, duplicate-key, missing-key and
// extreme-value cases, then phases of random push, pop and remove traffic
// that swing the queue between empty and full. Idle gaps are inserted at
// random, with one stretch without gaps. A separate checker predicts and
// compares every result.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import oqvr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 800;
    localparam int PHASE_ITEMS  = 40;
    localparam int RUN_LIMIT    = 300000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_traffic_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_in  i_cmd;
    logic busy;
    t_out o_result;
    logic o_strobe;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ordered_queue_with_value_removal #(
        .QUEUE_DEPTH(16),
        .VALUE_WIDTH(32)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_result(o_result),
        .o_strobe(o_strobe)
    );

    oqvr_result_check #(
        .QUEUE_DEPTH(16)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_result     (o_result),
        .i_strobe     (o_strobe),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [RES_W-1:0] pick_operand(input int unsigned pool_pct);
        if ($urandom_range(99) < pool_pct) begin
            case ($urandom_range(7))
                0: return 32'h0000_0000;
                1: return 32'hFFFF_FFFF;
                2: return 32'h8000_0000;
                3: return 32'h7FFF_FFFF;
                4: return 32'h0000_0001;
                5: return 32'h0000_0002;
                6: return 32'h5555_5555;
                default: return 32'hAAAA_AAAA;
            endcase
        end
        return $urandom;
    endfunction

    task automatic issue_queue_op(input logic [OP_W-1:0] op, input logic [RES_W-1:0] val,
                                  input bit may_idle);
        bit taken;
        while (may_idle && $urandom_range(99) < 22) begin
            start               = 1'b0;
            i_cmd.operation     = OP_W'($urandom);
            i_cmd.operand_value = $urandom;
            @(negedge i_clk);
        end
        start               = 1'b1;
        i_cmd.operation     = op;
        i_cmd.operand_value = val;
        taken               = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_traffic_mode mode;
        int unsigned   roll;
        logic [OP_W-1:0] op;
        start   = 1'b0;
        i_cmd   = '0;
        i_rst_n = 1'b0;
        mode    = MODE_FILL;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        issue_queue_op(OP_POP,    32'd0,        1'b1);
        issue_queue_op(OP_REMOVE, 32'd0,        1'b1);
        issue_queue_op(OP_UNUSED, 32'hFFFF_FFFF, 1'b1);
        issue_queue_op(OP_PUSH,   32'h8000_0000, 1'b1);
        issue_queue_op(OP_PUSH,   32'h7FFF_FFFF, 1'b1);
        issue_queue_op(OP_PUSH,   32'h0000_0000, 1'b1);
        issue_queue_op(OP_PUSH,   32'hFFFF_FFFF, 1'b1);
        issue_queue_op(OP_PUSH,   32'd5,        1'b1);
        issue_queue_op(OP_PUSH,   32'd5,        1'b1);
        issue_queue_op(OP_REMOVE, 32'd5,        1'b1);
        issue_queue_op(OP_REMOVE, 32'd1234,     1'b1);
        issue_queue_op(OP_POP,    32'hFFFF_FFFF, 1'b1);
        issue_queue_op(OP_REMOVE, 32'h0000_0000, 1'b1);
        for (int i = 0; i < 12; i++) begin
            issue_queue_op(OP_PUSH, 32'd100 + 3 * i, 1'b1);
        end
        issue_queue_op(OP_PUSH,   32'd42,        1'b1);
        issue_queue_op(OP_PUSH,   32'd99,        1'b1);
        issue_queue_op(OP_UNUSED, 32'd0,         1'b1);
        issue_queue_op(OP_REMOVE, 32'd42,        1'b1);
        issue_queue_op(OP_REMOVE, 32'h7FFF_FFFF, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                mode = t_traffic_mode'($urandom_range(2));
            end
            roll = $urandom_range(99);
            case (mode)
                MODE_FILL:  op = (roll < 60) ? OP_PUSH : (roll < 75) ? OP_POP :
                                 (roll < 95) ? OP_REMOVE : OP_UNUSED;
                MODE_DRAIN: op = (roll < 20) ? OP_PUSH : (roll < 50) ? OP_POP :
                                 (roll < 95) ? OP_REMOVE : OP_UNUSED;
                default:    op = (roll < 40) ? OP_PUSH : (roll < 65) ? OP_POP :
                                 (roll < 95) ? OP_REMOVE : OP_UNUSED;
            endcase
            issue_queue_op(op, pick_operand((op == OP_REMOVE) ? 70 : 60),
                           !(n >= 300 && n < 500));
        end
        start = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/oqvr_pkg.sv
sv/oqvr_ram.sv
sv/oqvr_ctrl.sv
sv/oqvr_dpath.sv
sv/ordered_queue_with_value_removal.sv
sv/oqvr_chk.sv
test/oqvr_result_check.sv
test/testbench.sv
